### sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types of the sensor frame deframer: header bytes,
// frame byte positions and the result record passed to the output stage.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Header bytes: delimiter, then length high and low
  localparam logic [7:0] HDR_DELIM  = 8'h7E;
  localparam logic [7:0] HDR_LEN_HI = 8'h00;
  localparam logic [7:0] HDR_LEN_LO = 8'h14;

  // Byte positions inside one 24-byte frame
  localparam logic [4:0] BODY_FIRST  = 5'd3;
  localparam logic [4:0] WORDS_FIRST = 5'd13;
  localparam logic [4:0] CHECK_POS   = 5'd23;

  // Captured payload bytes (frame bytes 13..22)
  localparam int PAYLOAD_DEPTH = 10;
  localparam int PAYLOAD_IW    = $clog2(PAYLOAD_DEPTH);

  // Checksum complement base
  localparam logic [7:0] SUM_BASE = 8'hFF;

  // One finished frame
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] emg_second;
    logic [15:0] emg_first;
    logic [15:0] acc_x;
    logic [15:0] acc_y;
    logic [15:0] acc_z;
  } result_t;

endpackage

### sv/sensor_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer_core
// Deframes received serial bytes into 24-byte sensor frames.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transaction. The block hunts for the
//   header 7E 00 14, sums bytes 3..22 modulo 256 and captures bytes 13..22.
//   A broken header goes back to hunting; a 7E at the break opens a new one.
//   m_axis carries one transaction per frame, on byte 23: tuser is the check
//   flag (byte 23 == 255 - sum), tdata holds the five 16-bit words. Words are
//   sent whatever the check says.
//   Throughput: one byte per cycle while the result register has room; each
//   byte is handled by a compare, an add and a capture between the parser
//   registers and the result register.
//   Output: the frame result is on m_axis in the cycle after byte 23 is taken.
//   Stall: the result register holds the record while m_axis_tready is low;
//   s_axis_tready then drops until the record is taken, and rises again in
//   the same cycle that the receiver takes it.
//   Reset (rst, synchronous): hunting for a header, no result pending.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [15:0] acc_z, [31:16] acc_y, [47:32] acc_x,
                                      // [63:48] emg_first, [79:64] emg_second
  output logic [0:0]  m_axis_tuser    // [0] frame_ok
);

  logic             accept;
  logic             res_valid;
  logic             out_room;
  sfd_pkg::result_t res;
  sfd_pkg::result_t out_rec;

  // Input transaction
  assign s_axis_tready = out_room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .load_data (res),
    .in_ready  (out_room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_rec)
  );

  // Output packing, first word lowest
  assign m_axis_tdata = {out_rec.emg_second, out_rec.emg_first, out_rec.acc_x,
                         out_rec.acc_y, out_rec.acc_z};
  assign m_axis_tuser = out_rec.frame_ok;

endmodule

### sv/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Header hunt, body byte counter, running sum and payload capture. Flags the
// checksum byte and presents the finished frame record combinationally.
// ----------------------------------------------------------------------------
module sfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,     // byte taken this cycle
  input  logic [7:0]       rx_byte,
  output logic             res_valid,  // current byte closes a frame
  output sfd_pkg::result_t res
);

  // Header phase codes
  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_DELIM = 2'd1;
  localparam logic [1:0] PH_LENHI = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0] phase, phase_next;
  logic [4:0] pos, pos_next;
  logic [7:0] sum, sum_next;
  logic [7:0] payload [sfd_pkg::PAYLOAD_DEPTH];

  logic       in_body_data;
  logic       cap_en;
  logic [4:0] cap_off;
  logic [1:0] restart_phase;

  // Body byte classification
  assign in_body_data = (pos >= sfd_pkg::BODY_FIRST) && (pos < sfd_pkg::CHECK_POS);
  assign cap_en       = in_body_data && (pos >= sfd_pkg::WORDS_FIRST);
  assign cap_off      = pos - sfd_pkg::WORDS_FIRST;
  assign res_valid    = (phase == PH_BODY) && !in_body_data;

  // A delimiter seen where the header breaks starts a new header
  assign restart_phase = (rx_byte == sfd_pkg::HDR_DELIM) ? PH_DELIM : PH_HUNT;

  // Next state
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    sum_next   = sum;
    unique case (phase)
      PH_HUNT: begin
        phase_next = restart_phase;
      end
      PH_DELIM: begin
        if (rx_byte == sfd_pkg::HDR_LEN_HI) begin
          phase_next = PH_LENHI;
        end else begin
          phase_next = restart_phase;
        end
      end
      PH_LENHI: begin
        if (rx_byte == sfd_pkg::HDR_LEN_LO) begin
          phase_next = PH_BODY;
          pos_next   = sfd_pkg::BODY_FIRST;
          sum_next   = 8'd0;
        end else begin
          phase_next = restart_phase;
        end
      end
      PH_BODY: begin
        if (in_body_data) begin
          sum_next = sum + rx_byte;
          pos_next = pos + 5'd1;
        end else begin
          phase_next = PH_HUNT;
          pos_next   = 5'd0;
          sum_next   = 8'd0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      pos   <= 5'd0;
      sum   <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      pos   <= pos_next;
      sum   <= sum_next;
    end
  end

  // Payload capture, bytes 13..22
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_BODY) && cap_en) begin
      payload[cap_off[sfd_pkg::PAYLOAD_IW-1:0]] <= rx_byte;
    end
  end

  // Frame record: check result plus big-endian words
  always_comb begin
    res.frame_ok   = ((sfd_pkg::SUM_BASE - sum) == rx_byte);
    res.acc_z      = {payload[0], payload[1]};
    res.acc_y      = {payload[2], payload[3]};
    res.acc_x      = {payload[4], payload[5]};
    res.emg_first  = {payload[6], payload[7]};
    res.emg_second = {payload[8], payload[9]};
  end

`ifndef NO_ASSERTIONS
  // Body position stays inside the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (pos >= sfd_pkg::BODY_FIRST && pos <= sfd_pkg::CHECK_POS))
    else $error("body position out of range");

  // A closed frame returns to hunting with a clean sum
  a_close: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid) |=> (phase == PH_HUNT && sum == 8'd0 && pos == 5'd0))
    else $error("frame close did not clear state");

  // A delimiter while hunting always opens a header
  a_delim: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_HUNT && rx_byte == sfd_pkg::HDR_DELIM) |=> (phase == PH_DELIM))
    else $error("delimiter missed");
`endif

endmodule

### sv/sfd_out_stage.sv
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register toward the master side. Holds one frame record while the
// receiver stalls and frees itself in the same cycle it is taken.
// ----------------------------------------------------------------------------
module sfd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,       // new record this cycle
  input  sfd_pkg::result_t load_data,
  output logic             in_ready,   // room for a record this cycle
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t out_data
);

  logic valid, valid_next;
  sfd_pkg::result_t data;

  // Free when empty or when the held record leaves now
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    if (load) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

`ifndef NO_ASSERTIONS
  // Never load over a record that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> in_ready)
    else $error("result overwritten while stalled");

  // A load is shown on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> valid)
    else $error("loaded record not presented");

  // A taken record with nothing new leaves the register empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (valid && out_ready && !load) |=> !valid)
    else $error("record repeated after transaction");
`endif

endmodule

### sim/tb_sensor_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer_core
// Self-checking bench for the sensor frame deframer. A byte stream is pushed
// into s_axis. It holds one directed header and frame sequence, then random
// frames with good and bad checksums, broken headers and line noise. A
// scoreboard tracks the header hunt, the running sum and the captured words,
// and checks every frame record that leaves m_axis. Both handshakes idle at
// random, and one long receiver hold-off backs the stream up to the input.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 430;
  localparam int MAX_REPORTS  = 10;

  // Header hunt phases
  typedef enum logic [1:0] {HUNT, SEEN_DELIM, SEEN_LEN_HI, IN_BODY} hdr_phase_t;

  // Tracks the deframer state and holds the frame records still due
  class frame_scoreboard;
    hdr_phase_t         phase;
    logic [4:0]         pos;
    logic [7:0]         sum;
    logic [7:0]         payload [sfd_pkg::PAYLOAD_DEPTH];
    sfd_pkg::result_t   frames_due [$];
    int                 mismatches;
    int                 frames_seen;
    int                 bad_sums;

    function new();
      phase       = HUNT;
      pos         = '0;
      sum         = '0;
      mismatches  = 0;
      frames_seen = 0;
      bad_sums    = 0;
    endfunction

    // A broken header falls back to hunting, or to a fresh delimiter
    function void restart_on(logic [7:0] b);
      phase = (b == sfd_pkg::HDR_DELIM) ? SEEN_DELIM : HUNT;
    endfunction

    // One accepted byte: advance the hunt or the body, queue a finished frame
    function void note_rx_byte(logic [7:0] b);
      sfd_pkg::result_t r;
      case (phase)
        HUNT: begin
          restart_on(b);
        end
        SEEN_DELIM: begin
          if (b == sfd_pkg::HDR_LEN_HI) phase = SEEN_LEN_HI;
          else restart_on(b);
        end
        SEEN_LEN_HI: begin
          if (b == sfd_pkg::HDR_LEN_LO) begin
            phase = IN_BODY;
            pos   = sfd_pkg::BODY_FIRST;
            sum   = '0;
          end else begin
            restart_on(b);
          end
        end
        default: begin
          if (pos >= sfd_pkg::BODY_FIRST && pos < sfd_pkg::CHECK_POS) begin
            sum = sum + b;
            if (pos >= sfd_pkg::WORDS_FIRST) payload[pos - sfd_pkg::WORDS_FIRST] = b;
            pos = pos + 5'd1;
          end else begin
            // checksum byte closes the frame
            r.frame_ok   = ((sfd_pkg::SUM_BASE - sum) == b);
            r.acc_z      = {payload[0], payload[1]};
            r.acc_y      = {payload[2], payload[3]};
            r.acc_x      = {payload[4], payload[5]};
            r.emg_first  = {payload[6], payload[7]};
            r.emg_second = {payload[8], payload[9]};
            if (!r.frame_ok) bad_sums++;
            frames_due.push_back(r);
            phase = HUNT;
            pos   = '0;
            sum   = '0;
          end
        end
      endcase
    endfunction

    // One accepted frame record against the oldest one due
    function void check_frame(sfd_pkg::result_t got);
      sfd_pkg::result_t want;
      string            diffs;
      diffs = "";
      if (frames_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("MISMATCH: frame record with none due, tuser=%0b tdata=%h",
                   got.frame_ok, {got.emg_second, got.emg_first, got.acc_x,
                                  got.acc_y, got.acc_z});
        return;
      end
      want = frames_due.pop_front();
      frames_seen++;
      if (want.frame_ok   != got.frame_ok)   diffs = {diffs, " frame_ok"};
      if (want.acc_z      != got.acc_z)      diffs = {diffs, " acc_z"};
      if (want.acc_y      != got.acc_y)      diffs = {diffs, " acc_y"};
      if (want.acc_x      != got.acc_x)      diffs = {diffs, " acc_x"};
      if (want.emg_first  != got.emg_first)  diffs = {diffs, " emg_first"};
      if (want.emg_second != got.emg_second) diffs = {diffs, " emg_second"};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("MISMATCH frame %0d:%s", frames_seen, diffs);
          $display("  want ok=%0b z=%h y=%h x=%h e1=%h e2=%h", want.frame_ok,
                   want.acc_z, want.acc_y, want.acc_x, want.emg_first,
                   want.emg_second);
          $display("  got  ok=%0b z=%h y=%h x=%h e1=%h e2=%h", got.frame_ok,
                   got.acc_z, got.acc_y, got.acc_x, got.emg_first,
                   got.emg_second);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [79:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  frame_scoreboard sb;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int bytes_sent    = 0;
  int input_stalls  = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;

  // Directed body: delimiter and header bytes as data, extreme words
  logic [7:0] dir_body [20] = '{8'h7E, 8'h00, 8'h14, 8'hFF, 8'h00, 8'hFF, 8'h7E,
                                8'h01, 8'h80, 8'h55, 8'hFF, 8'hFF, 8'h00, 8'h00,
                                8'h80, 8'h01, 8'h7E, 8'h7E, 8'h00, 8'hFF};

  sensor_frame_deframer_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Transaction monitors, sampled on pre-edge values
  always @(posedge clk) begin
    sfd_pkg::result_t got;
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_rx_byte(s_axis_tdata);
    if (!rst && s_axis_tvalid && !s_axis_tready) input_stalls++;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.frame_ok   = m_axis_tuser[0];
      got.acc_z      = m_axis_tdata[15:0];
      got.acc_y      = m_axis_tdata[31:16];
      got.acc_x      = m_axis_tdata[47:32];
      got.emg_first  = m_axis_tdata[63:48];
      got.emg_second = m_axis_tdata[79:64];
      sb.check_frame(got);
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d frame records still due", cycle_cnt,
             sb.frames_due.size());
    $display("tb_sensor_frame_deframer_core: errors");
    $finish;
  end

  // Mostly uniform bytes, with header and extreme values mixed in
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return sfd_pkg::HDR_DELIM;
      1:       return 8'h00;
      2:       return 8'hFF;
      3:       return sfd_pkg::HDR_LEN_LO;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one byte, idling first at random, and wait for the transaction
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Header, 20 body bytes (byte i at [8i+7:8i]) and a good or bad checksum
  task automatic send_frame(input logic [159:0] body, input bit good_check);
    logic [7:0] s;
    logic [7:0] chk;
    s = '0;
    send_byte(sfd_pkg::HDR_DELIM);
    send_byte(sfd_pkg::HDR_LEN_HI);
    send_byte(sfd_pkg::HDR_LEN_LO);
    for (int i = 0; i < 20; i++) begin
      send_byte(body[8*i +: 8]);
      s = s + body[8*i +: 8];
    end
    chk = sfd_pkg::SUM_BASE - s;
    if (!good_check) chk = chk + 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // Random traffic: mostly frames, some broken headers and noise
  task automatic run_phase(input int n_items);
    int          stop_at;
    int          r;
    logic [159:0] body;
    logic [7:0]  b;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        for (int i = 0; i < 20; i++) body[8*i +: 8] = pick_byte();
        send_frame(body, $urandom_range(0, 3) != 0);
      end else if (r < 88) begin
        send_byte(sfd_pkg::HDR_DELIM);
        if ($urandom_range(0, 1)) begin
          send_byte(sfd_pkg::HDR_LEN_HI);
          b = pick_byte();
          if (b == sfd_pkg::HDR_LEN_LO) b = sfd_pkg::HDR_DELIM;
        end else begin
          b = pick_byte();
          if (b == sfd_pkg::HDR_LEN_HI) b = 8'hFF;
        end
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end
    end
  endtask

  initial begin
    logic [159:0] body;
    sb = new();
    src_idle_pct  = 22;
    sink_idle_pct = 58;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Delimiter restarts in both header phases, then a frame with 7E in it
    send_byte(sfd_pkg::HDR_DELIM);
    send_byte(sfd_pkg::HDR_DELIM);
    send_byte(sfd_pkg::HDR_LEN_HI);
    send_byte(sfd_pkg::HDR_DELIM);
    for (int i = 0; i < 20; i++) body[8*i +: 8] = dir_body[i];
    send_frame(body, 1'b1);

    run_phase(PHASE_ITEMS);
    src_idle_pct  = 58;
    sink_idle_pct = 22;
    run_phase(PHASE_ITEMS);

    // No idling; a long receiver hold-off backs the stream up first
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_requests++;
    run_phase(PHASE_ITEMS);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes and %0d frame records (%0d with a bad checksum)",
             bytes_sent, sb.frames_seen, sb.bad_sums);
    $display("input stalled %0d cycles; %0d mismatches", input_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
      $display("tb_sensor_frame_deframer_core: clean");
    end else begin
      $display("tb_sensor_frame_deframer_core: errors");
    end
    $finish;
  end

endmodule

### sensor_frame_deframer_core.f
sv/sfd_pkg.sv
sv/sfd_parser.sv
sv/sfd_out_stage.sv
sv/sensor_frame_deframer_core.sv
sim/tb_sensor_frame_deframer_core.sv
